// File: design/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and codes shared by the message language tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned QDEPTH  = 3;
  localparam int unsigned QCNT_W  = 2;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_SYM     = 4'd2,
    MODE_IDENT   = 4'd3,
    MODE_NUM     = 4'd4,
    MODE_STR     = 4'd5,
    MODE_CH_OPEN = 4'd6,
    MODE_CH_BODY = 4'd7,
    MODE_AT      = 4'd8,
    MODE_LT      = 4'd9,
    MODE_FAILED  = 4'd10
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd2;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd5;
  localparam logic [KIND_W-1:0] KIND_CHAR    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_AT_SQ   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_AT_CURL = 5'd8;
  localparam logic [KIND_W-1:0] KIND_ARROW   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_EQ      = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_COLON   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_PIPE    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_LPAR    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_RPAR    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LSQ     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_RSQ     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_LCURL   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_RCURL   = 5'd19;

  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQ    = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LCURL  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURL  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic              has_char;
    logic [CHAR_W-1:0] text_char;
    logic              token_done;
    logic [KIND_W-1:0] token_kind;
    logic              fault;
    logic              last;
  } res_t;

  typedef struct packed {
    logic  vld;
    res_t  res;
    mode_t mode;
  } start_t;

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_EQ:    k = KIND_EQ;
      CH_SEMI:  k = KIND_SEMI;
      CH_COLON: k = KIND_COLON;
      CH_PIPE:  k = KIND_PIPE;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      CH_LSQ:   k = KIND_LSQ;
      CH_RSQ:   k = KIND_RSQ;
      CH_LCURL: k = KIND_LCURL;
      CH_RCURL: k = KIND_RCURL;
      default:  k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic res_t res_text(logic [CHAR_W-1:0] c, logic done,
                                    logic [KIND_W-1:0] kind);
    res_t r;
    r.has_char   = 1'b1;
    r.text_char  = c;
    r.token_done = done;
    r.token_kind = done ? kind : KIND_END;
    r.fault      = 1'b0;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic res_t res_done(logic [KIND_W-1:0] kind);
    res_t r;
    r.has_char   = 1'b0;
    r.text_char  = '0;
    r.token_done = 1'b1;
    r.token_kind = kind;
    r.fault      = 1'b0;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic res_t res_err();
    res_t r;
    r.has_char   = 1'b0;
    r.text_char  = '0;
    r.token_done = 1'b0;
    r.token_kind = KIND_END;
    r.fault      = 1'b1;
    r.last       = 1'b0;
    return r;
  endfunction

  // character seen between tokens
  function automatic start_t start_tok(logic [CHAR_W-1:0] c);
    start_t s;
    logic [KIND_W-1:0] k;
    k      = punct_kind(c);
    s.vld  = 1'b1;
    s.res  = res_text(c, 1'b0, KIND_END);
    s.mode = MODE_IDLE;
    priority if (is_space(c)) begin
      s.vld = 1'b0;
    end else if (c == CH_HASH) begin
      s.vld  = 1'b0;
      s.mode = MODE_COMMENT;
    end else if (c == CH_DOLLAR) begin
      s.mode = MODE_SYM;
    end else if (is_alpha(c)) begin
      s.mode = MODE_IDENT;
    end else if (is_digit(c)) begin
      s.mode = MODE_NUM;
    end else if (c == CH_DQUOTE) begin
      s.mode = MODE_STR;
    end else if (c == CH_SQUOTE) begin
      s.mode = MODE_CH_OPEN;
    end else if (c == CH_AT) begin
      s.mode = MODE_AT;
    end else if (c == CH_LT) begin
      s.mode = MODE_LT;
    end else if (k != KIND_END) begin
      s.res = res_text(c, 1'b1, k);
    end else begin
      s.res  = res_err();
      s.mode = MODE_FAILED;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/message_language_tokenizer.sv
// ----------------------------------------------------------------------------
// message_language_tokenizer
// Character stream tokenizer: one byte per word in, token text and token
// marks out, through a three-entry result queue.
// ----------------------------------------------------------------------------
// results are registered in the result queue and leave from its head
// throughput: one input word per cycle while out_stall is low and each word
//   gives at most one result; two results stall input until one is taken
// reset: synchronous active low, lexer back to idle, result queue empty
// ----------------------------------------------------------------------------
`default_nettype none

module message_language_tokenizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mlt_pkg::CHAR_W-1:0]  in_ch,
  input  wire logic                        in_end_of_input,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_has_char,
  output logic [mlt_pkg::CHAR_W-1:0]       out_text_char,
  output logic                             out_token_done,
  output logic [mlt_pkg::KIND_W-1:0]       out_token_kind,
  output logic                             out_fault,
  output logic                             out_last
);

  mlt_pkg::mode_t mode_r, mode_nxt;
  mlt_pkg::res_t  q_r   [mlt_pkg::QDEPTH];
  mlt_pkg::res_t  q_nxt [mlt_pkg::QDEPTH];
  logic [mlt_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  mlt_pkg::res_t  r0, r1;
  logic [1:0]     nres;
  mlt_pkg::start_t st;
  logic           push, pop;
  logic [mlt_pkg::QCNT_W-1:0] keep;

  // lexer step
  always_comb begin
    r0       = mlt_pkg::res_err();
    r1       = mlt_pkg::res_err();
    nres     = 2'd0;
    mode_nxt = mode_r;
    st       = mlt_pkg::start_tok(in_ch);
    if (mode_r == mlt_pkg::MODE_FAILED) begin
      nres = 2'd1;
    end else if (in_end_of_input) begin
      unique case (mode_r)
        mlt_pkg::MODE_SYM, mlt_pkg::MODE_IDENT, mlt_pkg::MODE_NUM: begin
          r0 = mlt_pkg::res_done((mode_r == mlt_pkg::MODE_SYM) ? mlt_pkg::KIND_SYMBOL :
                                 (mode_r == mlt_pkg::MODE_IDENT) ? mlt_pkg::KIND_IDENT :
                                 mlt_pkg::KIND_NUMBER);
          r1       = mlt_pkg::res_done(mlt_pkg::KIND_END);
          nres     = 2'd2;
          mode_nxt = mlt_pkg::MODE_IDLE;
        end
        mlt_pkg::MODE_STR, mlt_pkg::MODE_CH_OPEN, mlt_pkg::MODE_CH_BODY,
        mlt_pkg::MODE_AT, mlt_pkg::MODE_LT: begin
          nres     = 2'd1;
          mode_nxt = mlt_pkg::MODE_FAILED;
        end
        default: begin
          r0       = mlt_pkg::res_done(mlt_pkg::KIND_END);
          nres     = 2'd1;
          mode_nxt = mlt_pkg::MODE_IDLE;
        end
      endcase
    end else begin
      unique case (mode_r)
        mlt_pkg::MODE_COMMENT: begin
          if (in_ch == mlt_pkg::CH_NL) begin
            mode_nxt = mlt_pkg::MODE_IDLE;
          end
        end
        mlt_pkg::MODE_SYM, mlt_pkg::MODE_IDENT, mlt_pkg::MODE_NUM: begin
          priority if ((mode_r == mlt_pkg::MODE_NUM) ? mlt_pkg::is_digit(in_ch) :
                       (mlt_pkg::is_alpha(in_ch) || mlt_pkg::is_digit(in_ch))) begin
            r0   = mlt_pkg::res_text(in_ch, 1'b0, mlt_pkg::KIND_END);
            nres = 2'd1;
          end else if ((mode_r == mlt_pkg::MODE_IDENT) && (in_ch == mlt_pkg::CH_COLON)) begin
            r0       = mlt_pkg::res_text(in_ch, 1'b1, mlt_pkg::KIND_KEYWORD);
            nres     = 2'd1;
            mode_nxt = mlt_pkg::MODE_IDLE;
          end else begin
            r0 = mlt_pkg::res_done((mode_r == mlt_pkg::MODE_SYM) ? mlt_pkg::KIND_SYMBOL :
                                   (mode_r == mlt_pkg::MODE_IDENT) ? mlt_pkg::KIND_IDENT :
                                   mlt_pkg::KIND_NUMBER);
            r1       = st.res;
            nres     = st.vld ? 2'd2 : 2'd1;
            mode_nxt = st.mode;
          end
        end
        mlt_pkg::MODE_STR: begin
          r0   = mlt_pkg::res_text(in_ch, in_ch == mlt_pkg::CH_DQUOTE, mlt_pkg::KIND_STRING);
          nres = 2'd1;
          if (in_ch == mlt_pkg::CH_DQUOTE) begin
            mode_nxt = mlt_pkg::MODE_IDLE;
          end
        end
        mlt_pkg::MODE_CH_OPEN: begin
          r0       = mlt_pkg::res_text(in_ch, 1'b0, mlt_pkg::KIND_END);
          nres     = 2'd1;
          mode_nxt = mlt_pkg::MODE_CH_BODY;
        end
        mlt_pkg::MODE_CH_BODY: begin
          nres = 2'd1;
          if (in_ch == mlt_pkg::CH_SQUOTE) begin
            r0       = mlt_pkg::res_text(in_ch, 1'b1, mlt_pkg::KIND_CHAR);
            mode_nxt = mlt_pkg::MODE_IDLE;
          end else begin
            mode_nxt = mlt_pkg::MODE_FAILED;
          end
        end
        mlt_pkg::MODE_AT: begin
          nres = 2'd1;
          priority if (in_ch == mlt_pkg::CH_LSQ) begin
            r0       = mlt_pkg::res_text(in_ch, 1'b1, mlt_pkg::KIND_AT_SQ);
            mode_nxt = mlt_pkg::MODE_IDLE;
          end else if (in_ch == mlt_pkg::CH_LCURL) begin
            r0       = mlt_pkg::res_text(in_ch, 1'b1, mlt_pkg::KIND_AT_CURL);
            mode_nxt = mlt_pkg::MODE_IDLE;
          end else begin
            mode_nxt = mlt_pkg::MODE_FAILED;
          end
        end
        mlt_pkg::MODE_LT: begin
          nres = 2'd1;
          if (in_ch == mlt_pkg::CH_MINUS) begin
            r0       = mlt_pkg::res_text(in_ch, 1'b1, mlt_pkg::KIND_ARROW);
            mode_nxt = mlt_pkg::MODE_IDLE;
          end else begin
            mode_nxt = mlt_pkg::MODE_FAILED;
          end
        end
        default: begin
          r0       = st.res;
          nres     = st.vld ? 2'd1 : 2'd0;
          mode_nxt = st.mode;
        end
      endcase
    end
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  // result queue
  assign pop      = out_valid && !out_stall;
  assign in_stall = (cnt_r > 2'd1);
  assign push     = in_valid && !in_stall;
  assign keep     = cnt_r - {1'b0, pop};

  always_comb begin
    mlt_pkg::res_t base;
    logic [mlt_pkg::QCNT_W-1:0] off;
    cnt_nxt = keep + (push ? nres : 2'd0);
    for (int i = 0; i < mlt_pkg::QDEPTH; i++) begin
      base = (pop && (i < mlt_pkg::QDEPTH - 1)) ? q_r[(i + 1) % mlt_pkg::QDEPTH] : q_r[i];
      off  = mlt_pkg::QCNT_W'(i) - keep;
      if (mlt_pkg::QCNT_W'(i) < keep) begin
        q_nxt[i] = base;
      end else if (push && (off == 2'd0)) begin
        q_nxt[i] = r0;
      end else if (push && (off == 2'd1)) begin
        q_nxt[i] = r1;
      end else begin
        q_nxt[i] = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mlt_pkg::MODE_IDLE;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < mlt_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_has_char   = q_r[0].has_char;
  assign out_text_char  = q_r[0].text_char;
  assign out_token_done = q_r[0].token_done;
  assign out_token_kind = q_r[0].token_kind;
  assign out_fault      = q_r[0].fault;
  assign out_last       = q_r[0].last;

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the message language tokenizer. Source bytes are
// queued up front: a short hand-picked run through every token form, then
// random well-formed token streams with end marks, and finally one lexer
// fault with a few bytes after it to show the fault sticks. A predictor
// tracks the lexer mode and lists the result words each accepted byte must
// give; the monitor checks every word field by field under random stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RANDOM_CHARS = 400;

  typedef logic [mlt_pkg::CHAR_W-1:0] char_t;

  typedef struct {
    logic [mlt_pkg::CHAR_W-1:0] ch;
    logic                       eoi;
    int unsigned                gap;
    bit                         drain;
  } src_char_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [mlt_pkg::CHAR_W-1:0] in_ch = '0;
  logic                       in_end_of_input = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_has_char;
  logic [mlt_pkg::CHAR_W-1:0] out_text_char;
  logic                       out_token_done;
  logic [mlt_pkg::KIND_W-1:0] out_token_kind;
  logic                       out_fault;
  logic                       out_last;

  src_char_t      char_q[$];
  mlt_pkg::res_t  token_q[$];
  mlt_pkg::res_t  step_q[$];
  mlt_pkg::mode_t lex_mode = mlt_pkg::MODE_IDLE;

  logic [mlt_pkg::CHAR_W-1:0] punct_set [10] = '{
    mlt_pkg::CH_EQ, mlt_pkg::CH_SEMI, mlt_pkg::CH_COLON, mlt_pkg::CH_PIPE,
    mlt_pkg::CH_LPAR, mlt_pkg::CH_RPAR, mlt_pkg::CH_LSQ, mlt_pkg::CH_RSQ,
    mlt_pkg::CH_LCURL, mlt_pkg::CH_RCURL};

  int unsigned gap_left = 0;
  int unsigned stall_run = 0;
  int unsigned idle_cycles = 0;
  int unsigned chars_in = 0;
  int unsigned words_seen = 0;
  int unsigned tokens_seen = 0;
  int unsigned drains = 0;
  int unsigned mismatches = 0;
  bit          busy = 1'b0;
  bit          force_drain = 1'b0;
  int unsigned phase_left = 0;

  message_language_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_has_char    (out_has_char),
    .out_text_char   (out_text_char),
    .out_token_done  (out_token_done),
    .out_token_kind  (out_token_kind),
    .out_fault       (out_fault),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // character classes and token words

  function automatic logic is_blank(logic [mlt_pkg::CHAR_W-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_numeral(logic [mlt_pkg::CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter_or_numeral(logic [mlt_pkg::CHAR_W-1:0] c);
    return is_numeral(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [mlt_pkg::KIND_W-1:0] punct_code(logic [mlt_pkg::CHAR_W-1:0] c);
    case (c)
      mlt_pkg::CH_EQ:    return mlt_pkg::KIND_EQ;
      mlt_pkg::CH_SEMI:  return mlt_pkg::KIND_SEMI;
      mlt_pkg::CH_COLON: return mlt_pkg::KIND_COLON;
      mlt_pkg::CH_PIPE:  return mlt_pkg::KIND_PIPE;
      mlt_pkg::CH_LPAR:  return mlt_pkg::KIND_LPAR;
      mlt_pkg::CH_RPAR:  return mlt_pkg::KIND_RPAR;
      mlt_pkg::CH_LSQ:   return mlt_pkg::KIND_LSQ;
      mlt_pkg::CH_RSQ:   return mlt_pkg::KIND_RSQ;
      mlt_pkg::CH_LCURL: return mlt_pkg::KIND_LCURL;
      mlt_pkg::CH_RCURL: return mlt_pkg::KIND_RCURL;
      default:           return mlt_pkg::KIND_END;
    endcase
  endfunction

  function automatic mlt_pkg::res_t word_of(logic has, logic [mlt_pkg::CHAR_W-1:0] c,
                                            logic done, logic [mlt_pkg::KIND_W-1:0] kind,
                                            logic err);
    mlt_pkg::res_t w;
    w.has_char   = has;
    w.text_char  = has ? c : '0;
    w.token_done = done;
    w.token_kind = done ? kind : mlt_pkg::KIND_END;
    w.fault      = err;
    w.last       = 1'b0;
    return w;
  endfunction

  task automatic text_word(input logic [mlt_pkg::CHAR_W-1:0] c);
    step_q.push_back(word_of(1'b1, c, 1'b0, mlt_pkg::KIND_END, 1'b0));
  endtask

  task automatic close_word(input logic [mlt_pkg::CHAR_W-1:0] c,
                            input logic [mlt_pkg::KIND_W-1:0] kind);
    step_q.push_back(word_of(1'b1, c, 1'b1, kind, 1'b0));
    lex_mode = mlt_pkg::MODE_IDLE;
  endtask

  task automatic done_word(input logic [mlt_pkg::KIND_W-1:0] kind);
    step_q.push_back(word_of(1'b0, '0, 1'b1, kind, 1'b0));
  endtask

  task automatic fault_word();
    step_q.push_back(word_of(1'b0, '0, 1'b0, mlt_pkg::KIND_END, 1'b1));
    lex_mode = mlt_pkg::MODE_FAILED;
  endtask

  // byte seen between tokens
  task automatic from_idle(input logic [mlt_pkg::CHAR_W-1:0] c);
    logic [mlt_pkg::KIND_W-1:0] k;
    k = punct_code(c);
    lex_mode = mlt_pkg::MODE_IDLE;
    if (is_blank(c)) begin
      return;
    end
    if (c == mlt_pkg::CH_HASH) begin
      lex_mode = mlt_pkg::MODE_COMMENT;
    end else if (c == mlt_pkg::CH_DOLLAR) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_SYM;
    end else if (is_letter_or_numeral(c) && !is_numeral(c)) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_IDENT;
    end else if (is_numeral(c)) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_NUM;
    end else if (c == mlt_pkg::CH_DQUOTE) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_STR;
    end else if (c == mlt_pkg::CH_SQUOTE) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_CH_OPEN;
    end else if (c == mlt_pkg::CH_AT) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_AT;
    end else if (c == mlt_pkg::CH_LT) begin
      text_word(c);
      lex_mode = mlt_pkg::MODE_LT;
    end else if (k != mlt_pkg::KIND_END) begin
      close_word(c, k);
    end else begin
      fault_word();
    end
  endtask

  // expected words for one accepted byte, appended to token_q
  task automatic lex_char(input logic [mlt_pkg::CHAR_W-1:0] c, input logic eoi);
    mlt_pkg::res_t w;
    step_q.delete();
    if (lex_mode == mlt_pkg::MODE_FAILED) begin
      fault_word();
    end else if (eoi) begin
      case (lex_mode)
        mlt_pkg::MODE_STR, mlt_pkg::MODE_CH_OPEN, mlt_pkg::MODE_CH_BODY, mlt_pkg::MODE_AT,
        mlt_pkg::MODE_LT: begin
          fault_word();
        end
        default: begin
          if (lex_mode == mlt_pkg::MODE_SYM) done_word(mlt_pkg::KIND_SYMBOL);
          else if (lex_mode == mlt_pkg::MODE_IDENT) done_word(mlt_pkg::KIND_IDENT);
          else if (lex_mode == mlt_pkg::MODE_NUM) done_word(mlt_pkg::KIND_NUMBER);
          done_word(mlt_pkg::KIND_END);
          lex_mode = mlt_pkg::MODE_IDLE;
        end
      endcase
    end else begin
      case (lex_mode)
        mlt_pkg::MODE_COMMENT: begin
          if (c == mlt_pkg::CH_NL) lex_mode = mlt_pkg::MODE_IDLE;
        end
        mlt_pkg::MODE_SYM: begin
          if (is_letter_or_numeral(c)) begin
            text_word(c);
          end else begin
            done_word(mlt_pkg::KIND_SYMBOL);
            from_idle(c);
          end
        end
        mlt_pkg::MODE_IDENT: begin
          if (is_letter_or_numeral(c)) begin
            text_word(c);
          end else if (c == mlt_pkg::CH_COLON) begin
            close_word(c, mlt_pkg::KIND_KEYWORD);
          end else begin
            done_word(mlt_pkg::KIND_IDENT);
            from_idle(c);
          end
        end
        mlt_pkg::MODE_NUM: begin
          if (is_numeral(c)) begin
            text_word(c);
          end else begin
            done_word(mlt_pkg::KIND_NUMBER);
            from_idle(c);
          end
        end
        mlt_pkg::MODE_STR: begin
          if (c == mlt_pkg::CH_DQUOTE) close_word(c, mlt_pkg::KIND_STRING);
          else text_word(c);
        end
        mlt_pkg::MODE_CH_OPEN: begin
          text_word(c);
          lex_mode = mlt_pkg::MODE_CH_BODY;
        end
        mlt_pkg::MODE_CH_BODY: begin
          if (c == mlt_pkg::CH_SQUOTE) close_word(c, mlt_pkg::KIND_CHAR);
          else fault_word();
        end
        mlt_pkg::MODE_AT: begin
          if (c == mlt_pkg::CH_LSQ) close_word(c, mlt_pkg::KIND_AT_SQ);
          else if (c == mlt_pkg::CH_LCURL) close_word(c, mlt_pkg::KIND_AT_CURL);
          else fault_word();
        end
        mlt_pkg::MODE_LT: begin
          if (c == mlt_pkg::CH_MINUS) close_word(c, mlt_pkg::KIND_ARROW);
          else fault_word();
        end
        default: begin
          from_idle(c);
        end
      endcase
    end
    if (step_q.size() != 0) begin
      w = step_q.pop_back();
      w.last = 1'b1;
      step_q.push_back(w);
    end
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // source byte generation

  task automatic add_char(input logic [mlt_pkg::CHAR_W-1:0] c, input logic eoi);
    src_char_t s;
    int unsigned r;
    if (phase_left == 0) begin
      busy = !busy;
      phase_left = $urandom_range(10, 60);
    end
    phase_left--;
    r = $urandom_range(0, 99);
    s.ch    = c;
    s.eoi   = eoi;
    s.gap   = !busy ? 0 : (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) :
              $urandom_range(6, 30);
    s.drain = force_drain || ($urandom_range(0, 59) == 0);
    force_drain = 1'b0;
    char_q.push_back(s);
  endtask

  task automatic add_end();
    add_char(char_t'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [mlt_pkg::CHAR_W-1:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return char_t'((r < 26) ? 32'h41 + r : 32'h61 + r - 26);
  endfunction

  function automatic logic [mlt_pkg::CHAR_W-1:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return char_t'(32'h30 + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  function automatic logic [mlt_pkg::CHAR_W-1:0] rand_byte_except(
      logic [mlt_pkg::CHAR_W-1:0] x, logic [mlt_pkg::CHAR_W-1:0] y);
    logic [mlt_pkg::CHAR_W-1:0] c;
    do c = char_t'($urandom_range(0, 255)); while (c == x || c == y);
    return c;
  endfunction

  task automatic add_ident();
    add_char(rand_letter(), 1'b0);
    repeat ($urandom_range(0, 6)) add_char(rand_alnum(), 1'b0);
  endtask

  task automatic add_token();
    int unsigned r;
    case ($urandom_range(0, 12))
      0: begin
        add_char(mlt_pkg::CH_DOLLAR, 1'b0);
        repeat ($urandom_range(0, 5)) add_char(rand_alnum(), 1'b0);
      end
      1, 2: add_ident();
      3: begin
        add_ident();
        add_char(mlt_pkg::CH_COLON, 1'b0);
      end
      4: repeat ($urandom_range(1, 5)) add_char(char_t'(32'h30 + $urandom_range(0, 9)), 1'b0);
      5: begin
        add_char(mlt_pkg::CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 6))
          add_char(rand_byte_except(mlt_pkg::CH_DQUOTE, mlt_pkg::CH_DQUOTE), 1'b0);
        add_char(mlt_pkg::CH_DQUOTE, 1'b0);
      end
      6: begin
        add_char(mlt_pkg::CH_SQUOTE, 1'b0);
        add_char(char_t'($urandom_range(0, 255)), 1'b0);
        add_char(mlt_pkg::CH_SQUOTE, 1'b0);
      end
      7: begin
        add_char(mlt_pkg::CH_AT, 1'b0);
        add_char($urandom_range(0, 1) ? mlt_pkg::CH_LSQ : mlt_pkg::CH_LCURL, 1'b0);
      end
      8: begin
        add_char(mlt_pkg::CH_LT, 1'b0);
        add_char(mlt_pkg::CH_MINUS, 1'b0);
      end
      9: add_char(punct_set[4'($urandom_range(0, 9))], 1'b0);
      10: begin
        add_char(mlt_pkg::CH_HASH, 1'b0);
        repeat ($urandom_range(0, 6))
          add_char(rand_byte_except(mlt_pkg::CH_NL, mlt_pkg::CH_NL), 1'b0);
        if ($urandom_range(0, 3) == 0) add_end();
        else add_char(mlt_pkg::CH_NL, 1'b0);
      end
      11: repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 6);
        add_char(char_t'((r == 6) ? 32'h20 : 32'h09 + r), 1'b0);
      end
      default: add_end();
    endcase
  endtask

  // source side

  always @(posedge clk) begin : drive
    src_char_t nxt;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_ch           <= '0;
      in_end_of_input <= 1'b0;
      gap_left        <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        lex_char(in_ch, in_end_of_input);
        chars_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (char_q.size() == 0 || (char_q[0].drain && token_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = char_q.pop_front();
          if (nxt.drain) drains++;
          in_valid        <= 1'b1;
          in_ch           <= nxt.ch;
          in_end_of_input <= nxt.eoi;
          gap_left        <= nxt.gap;
        end
      end
    end
  end

  // result side

  always @(posedge clk) begin : stall_gen
    int unsigned sel;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 8);
      end else if (sel < 65) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(20, 60);
      end else if (sel < 95) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(8, 30);
      end
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    // keep the log short when everything goes wrong
    if (mismatches < 100)
      $display("%0t: word %0d %s: got %0h, expected %0h", $realtime, words_seen, what, got,
               want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    mlt_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (out_token_done) tokens_seen++;
      if (token_q.size() == 0) begin
        report("arrived with nothing expected", 32'(out_text_char), 0);
      end else begin
        want = token_q.pop_front();
        if (out_has_char !== want.has_char)
          report("has_char", 32'(out_has_char), 32'(want.has_char));
        if (out_text_char !== want.text_char)
          report("text_char", 32'(out_text_char), 32'(want.text_char));
        if (out_token_done !== want.token_done)
          report("token_done", 32'(out_token_done), 32'(want.token_done));
        if (out_token_kind !== want.token_kind)
          report("token_kind", 32'(out_token_kind), 32'(want.token_kind));
        if (out_fault !== want.fault)
          report("fault", 32'(out_fault), 32'(want.fault));
        if (out_last !== want.last) report("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [mlt_pkg::CHAR_W-1:0] c;
    int unsigned                base;

    // symbol cut by '=', keyword, number cut by a letter, ident cut by ';'
    add_char(mlt_pkg::CH_DOLLAR, 1'b0);
    add_char(8'h5A, 1'b0);
    add_char(mlt_pkg::CH_EQ, 1'b0);
    add_char(8'h6B, 1'b0);
    add_char(mlt_pkg::CH_COLON, 1'b0);
    add_char(8'h39, 1'b0);
    add_char(8'h30, 1'b0);
    add_char(8'h61, 1'b0);
    add_char(mlt_pkg::CH_SEMI, 1'b0);
    add_char(mlt_pkg::CH_AT, 1'b0);
    add_char(mlt_pkg::CH_LCURL, 1'b0);
    add_char(mlt_pkg::CH_LT, 1'b0);
    add_char(mlt_pkg::CH_MINUS, 1'b0);
    add_char(mlt_pkg::CH_SQUOTE, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(mlt_pkg::CH_SQUOTE, 1'b0);
    add_char(mlt_pkg::CH_DQUOTE, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(mlt_pkg::CH_DQUOTE, 1'b0);
    add_char(mlt_pkg::CH_HASH, 1'b0);
    add_char(8'h80, 1'b0);
    add_char(mlt_pkg::CH_NL, 1'b0);
    add_char(8'h09, 1'b0);
    add_char(8'h0D, 1'b0);
    add_char(8'hFF, 1'b1);

    base = char_q.size();
    force_drain = 1'b1;
    while (char_q.size() < base + RANDOM_CHARS) add_token();

    // one fault at the very end, then bytes that must all stay failed
    force_drain = 1'b1;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: c = 8'h00;
          1: c = 8'h21;
          2: c = 8'h7F;
          default: c = char_t'($urandom_range(128, 255));
        endcase
        add_char(c, 1'b0);
      end
      1: begin
        add_char(mlt_pkg::CH_AT, 1'b0);
        add_char(rand_byte_except(mlt_pkg::CH_LSQ, mlt_pkg::CH_LCURL), 1'b0);
      end
      2: begin
        add_char(mlt_pkg::CH_LT, 1'b0);
        add_char(rand_byte_except(mlt_pkg::CH_MINUS, mlt_pkg::CH_MINUS), 1'b0);
      end
      3: begin
        add_char(mlt_pkg::CH_SQUOTE, 1'b0);
        add_char(char_t'($urandom_range(0, 255)), 1'b0);
        add_char(rand_byte_except(mlt_pkg::CH_SQUOTE, mlt_pkg::CH_SQUOTE), 1'b0);
      end
      4: begin
        add_char(mlt_pkg::CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 3))
          add_char(rand_byte_except(mlt_pkg::CH_DQUOTE, mlt_pkg::CH_DQUOTE), 1'b0);
        add_end();
      end
      default: begin
        add_char($urandom_range(0, 1) ? mlt_pkg::CH_AT : mlt_pkg::CH_LT, 1'b0);
        add_end();
      end
    endcase
    repeat (5) add_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d source bytes sent, %0d result words checked, %0d tokens completed",
             chars_in, words_seen, tokens_seen);
    $display("source held back %0d times until all results were out; run ends in a fault",
             drains);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
